// ----- hdl/bear_pkg.sv -----
// shared types and constants for the button edge and auto-repeat block
`default_nettype none

package bear_pkg;

  // standard gamepad bit layout
  localparam logic [15:0] PAD_SELECT    = 16'h0001;
  localparam logic [15:0] PAD_UP        = 16'h0010;
  localparam logic [15:0] PAD_RIGHT     = 16'h0020;
  localparam logic [15:0] PAD_DOWN      = 16'h0040;
  localparam logic [15:0] PAD_LEFT      = 16'h0080;
  localparam logic [15:0] PAD_L1        = 16'h0400;
  localparam logic [15:0] PAD_R1        = 16'h0800;
  localparam logic [15:0] PAD_SQUARE    = 16'h8000;
  localparam logic [15:0] PAD_DPAD_MASK = 16'h00F0;
  localparam logic [15:0] PAD_REPEATABLE = PAD_L1 | PAD_R1 | PAD_DPAD_MASK;

  localparam logic [2:0] COOLDOWN_ARM = 3'd5;
  localparam logic [15:0] HOLD_MAX = 16'hFFFF;
  localparam logic [7:0] REPEAT_MAX = 8'hFF;

  localparam logic [7:0] INITIAL_DELAY_RESET   = 8'd20;
  localparam logic [7:0] REPEAT_PERIOD_RESET   = 8'd4;
  localparam logic [7:0] SECONDARY_PERIOD_RESET = 8'd8;

  typedef enum logic [1:0] {
    REG_INITIAL_DELAY    = 2'd0,
    REG_REPEAT_PERIOD    = 2'd1,
    REG_SECONDARY_PERIOD = 2'd2
  } reg_index_t;

  typedef struct packed {
    logic [15:0] buttons;
    logic        threads_changed;
  } in_t;

  typedef struct packed {
    logic [15:0] new_buttons;
    logic [15:0] previous_buttons;
    logic [2:0]  cooldown;
  } out_t;

  typedef struct packed {
    logic [15:0] held_word;
    logic [15:0] hold_count;
    logic [7:0]  repeat_count;
    logic [7:0]  secondary_count;
    logic [2:0]  cooldown_count;
  } state_t;

  typedef struct packed {
    logic [7:0] initial_delay_frames;
    logic [7:0] repeat_period_frames;
    logic [7:0] secondary_period_frames;
  } cfg_t;

endpackage

`default_nettype wire

// ----- hdl/bear_step.sv -----
// per-frame edge detect, hold counting and auto-repeat update
`default_nettype none

module bear_step import bear_pkg::*; (
  input  in_t    item,
  input  state_t state,
  input  cfg_t   cfg,
  output state_t state_next,
  output out_t   result
);

  logic [15:0] cur;
  logic [15:0] repeatable;
  logic        changed;
  logic [15:0] hold_inc;
  logic [7:0]  repeat_inc;
  logic [7:0]  secondary_inc;
  logic [15:0] word;
  logic [2:0]  cool;

  assign cur        = item.buttons;
  assign repeatable = cur & PAD_REPEATABLE;
  assign changed    = (state.held_word != cur) || (repeatable == '0);

  assign hold_inc      = (state.hold_count == HOLD_MAX) ? HOLD_MAX : state.hold_count + 16'd1;
  assign repeat_inc    = (state.repeat_count == REPEAT_MAX) ? REPEAT_MAX
                         : state.repeat_count + 8'd1;
  assign secondary_inc = (state.secondary_count == REPEAT_MAX) ? REPEAT_MAX
                         : state.secondary_count + 8'd1;

  always_comb begin
    word = '0;
    state_next.held_word       = cur;
    state_next.hold_count      = '0;
    state_next.repeat_count    = state.repeat_count;
    state_next.secondary_count = state.secondary_count;

    if (changed) begin
      word = ~state.held_word & cur;
      // all buttons released clears the repeat counters too
      if (cur == '0) begin
        state_next.repeat_count    = '0;
        state_next.secondary_count = '0;
      end
    end else begin
      // unchanged with repeatables held implies cur is nonzero
      state_next.hold_count = hold_inc;
      if (hold_inc == {8'd0, cfg.initial_delay_frames}) begin
        word = repeatable;
      end
      if (hold_inc >= {8'd0, cfg.initial_delay_frames}) begin
        state_next.repeat_count    = repeat_inc;
        state_next.secondary_count = secondary_inc;
        if (repeat_inc >= cfg.repeat_period_frames) begin
          state_next.repeat_count = '0;
          if ((cur & PAD_SQUARE) != '0) begin
            word = cur & (PAD_RIGHT | PAD_LEFT);
          end else begin
            word = cur & PAD_DPAD_MASK;
          end
        end
        if (secondary_inc >= cfg.secondary_period_frames) begin
          state_next.secondary_count = '0;
          if ((cur & PAD_SQUARE) != '0) begin
            word = word | (cur & (PAD_L1 | PAD_R1 | PAD_UP | PAD_DOWN));
          end else begin
            word = word | (cur & (PAD_L1 | PAD_R1));
          end
        end
      end else begin
        state_next.repeat_count    = '0;
        state_next.secondary_count = '0;
      end
    end

    cool = state.cooldown_count;
    // select on its own does not arm the cooldown
    if ((word != PAD_SELECT && word != '0) || item.threads_changed) begin
      cool = COOLDOWN_ARM;
    end
    if (cool != '0) begin
      cool = cool - 3'd1;
    end
    state_next.cooldown_count = cool;

    result.new_buttons      = word;
    result.previous_buttons = state.held_word;
    result.cooldown         = cool;
  end

endmodule

`default_nettype wire

// ----- hdl/button_edge_auto_repeat_top.sv -----
// Button edge detect with typematic auto-repeat, one frame word per transfer.
// Each input transfer is latched into an input register, updated by
// combinational logic against the hold, repeat and cooldown counters, and
// lands in the result register. One frame is accepted every cycle while
// the result register is not stalled. The result register holds a stalled
// result while the input register keeps its frame and, once full, stalls
// the input. The user must write the delay and period registers through
// the cfg port only while no frame is in flight; the block does not
// enforce this. Indexes beyond the last register are ignored.
`default_nettype none

module button_edge_auto_repeat_top import bear_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  in_t        in_data,
  output logic       out_valid,
  input  logic       out_ready,
  output out_t       out_data,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_data
);

  cfg_t   cfg;
  state_t state;
  state_t state_next;
  out_t   result;
  logic   stage_valid;
  in_t    stage_data;
  logic   advance;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.initial_delay_frames    <= INITIAL_DELAY_RESET;
      cfg.repeat_period_frames    <= REPEAT_PERIOD_RESET;
      cfg.secondary_period_frames <= SECONDARY_PERIOD_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_INITIAL_DELAY:    cfg.initial_delay_frames    <= cfg_data;
        REG_REPEAT_PERIOD:    cfg.repeat_period_frames    <= cfg_data;
        REG_SECONDARY_PERIOD: cfg.secondary_period_frames <= cfg_data;
        default: ;
      endcase
    end
  end

  // result register free or draining this cycle
  assign advance  = !out_valid || out_ready;
  assign in_ready = !stage_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (in_ready) begin
      stage_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      stage_data <= in_data;
    end
  end

  bear_step u_step (
    .item       (stage_data),
    .state      (state),
    .cfg        (cfg),
    .state_next (state_next),
    .result     (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= '0;
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= stage_valid;
      if (stage_valid) begin
        state <= state_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance && stage_valid) begin
      out_data <= result;
    end
  end

endmodule

`default_nettype wire

// ----- hdl/bear_checker.sv -----
// port-level checks for the button edge and auto-repeat block
`default_nettype none

module bear_checker import bear_pkg::*; (
  input logic clk,
  input logic rst,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input out_t out_data
);

  // a stalled result holds
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // input side only stalls behind a stalled result
  assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid && !out_ready)
    else $error("input stalled without a stalled result");

  // any press other than select alone arms the cooldown
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.new_buttons != '0 && out_data.new_buttons != PAD_SELECT
      |-> out_data.cooldown == COOLDOWN_ARM - 3'd1)
    else $error("cooldown not armed by a press");

  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.cooldown < COOLDOWN_ARM)
    else $error("cooldown out of range");

endmodule

bind button_edge_auto_repeat_top bear_checker u_bear_checker (.*);

`default_nettype wire
